// ===== design/salc_pkg.sv =====
// Package for the set-associative LRU cache with next-line prefetch.
// Holds the state type, register indexes and fixed field widths; no dependencies.
package salc_pkg;

    localparam int STAMP_W     = 32;
    localparam int TOTAL_W     = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int OFF_CFG_W   = 5;
    localparam int SET_CFG_W   = 4;
    localparam int WAY_CFG_W   = 4;
    localparam logic [OFF_CFG_W-1:0] OFF_MAX = 5'd16;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFETCH_ENABLE = 2'd3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK_DEMAND,
        S_READ_PREFETCH,
        S_LOOK_PREFETCH,
        S_FINISH
    } t_state;

endpackage

// ===== design/salc_if.sv =====
// Channel interfaces: access input, result output and configuration write.
// Depends on salc_pkg for the fixed field widths.
interface salc_in_if #(parameter int ADDR_BITS = 48);
    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] address;
    logic                 mode;
    modport source (output valid, output address, output mode, input ready);
    modport sink   (input valid, input address, input mode, output ready);
endinterface

interface salc_out_if;
    logic                         valid;
    logic                         ready;
    logic                         was_hit;
    logic                         prefetch_filled;
    logic [salc_pkg::TOTAL_W-1:0] hit_total;
    logic [salc_pkg::TOTAL_W-1:0] miss_total;
    logic [salc_pkg::TOTAL_W-1:0] mem_read_total;
    logic [salc_pkg::TOTAL_W-1:0] mem_write_total;
    modport source (output valid, output was_hit, output prefetch_filled, output hit_total,
                    output miss_total, output mem_read_total, output mem_write_total,
                    input ready);
    modport sink   (input valid, input was_hit, input prefetch_filled, input hit_total,
                    input miss_total, input mem_read_total, input mem_write_total,
                    output ready);
endinterface

interface salc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [salc_pkg::CFG_IDX_W-1:0]  index;
    logic [salc_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/set_assoc_lru_cache_prefetch_unit.sv =====
// Set-associative write-through LRU cache model with next-line prefetch. Each set is one row
// of a single-port-write memory with registered read; an access reads its set, looks it up and
// writes it back; on a miss with prefetch enabled it also reads the next line's set and fills it
// if that line misses, and it then waits while the sink holds back the previous result. After
// reset a clearing pass writes one row a cycle to all 2^floor(log2(MAX_SETS)) rows, during which
// no access is taken. Depends on salc_pkg and salc_if.
module set_assoc_lru_cache_prefetch_unit #(
    parameter int MAX_SETS   = 256,
    parameter int MAX_WAYS   = 8,
    parameter int ADDR_BITS  = 48,
    parameter int COUNT_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    salc_in_if.sink     i_in,
    salc_out_if.source  o_out,
    salc_cfg_if.sink    i_cfg
);
    import salc_pkg::*;

    localparam int MSB    = $clog2(MAX_SETS + 1) - 1;
    localparam int DEPTH  = 1 << MSB;
    localparam int SET_W  = (MSB > 0) ? MSB : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W = $clog2(MAX_WAYS + 1);
    localparam int ENT_W  = 1 + STAMP_W + ADDR_BITS;
    localparam logic [SET_W-1:0] LAST_SET = SET_W'(DEPTH - 1);

    typedef logic [MAX_WAYS-1:0][ENT_W-1:0] t_row;

    t_row mem [DEPTH];
    t_row r_rd_row;

    t_state r_state, n_state;

    logic [OFF_CFG_W-1:0] r_cfg_off;
    logic [SET_CFG_W-1:0] r_cfg_sets;
    logic [WAY_CFG_W-1:0] r_cfg_ways;
    logic                 r_cfg_pf;

    logic [SET_W-1:0]      r_clr_idx, n_clr_idx;
    logic [ADDR_BITS-1:0]  r_addr, n_addr;
    logic                  r_mode, n_mode;
    logic [SET_W-1:0]      r_set, n_set;
    logic [ADDR_BITS-1:0]  r_tag, n_tag;
    logic [SET_W-1:0]      r_pset, n_pset;
    logic [ADDR_BITS-1:0]  r_ptag, n_ptag;
    logic [ADDR_BITS-1:0]  r_paddr, n_paddr;
    logic [STAMP_W-1:0]    r_clock, n_clock;
    logic [COUNT_BITS-1:0] r_hc, n_hc, r_mc, n_mc, r_rc, n_rc, r_wc, n_wc;
    logic                  r_hit, n_hit, r_pf, n_pf;
    logic                  r_oval, n_oval;

    logic [OFF_CFG_W-1:0]  w_off;
    logic [4:0]            w_sb;
    logic [WCNT_W-1:0]     w_ways;
    logic [SET_W-1:0]      w_smask;
    logic                  w_rd_en, w_wr_en;
    logic [SET_W-1:0]      w_rd_addr, w_wr_addr;
    t_row                  w_wr_row;

    logic [ADDR_BITS-1:0]  w_lk_tag;
    logic                  w_found, w_lk_hit;
    logic [WAY_W-1:0]      w_slot, w_victim;
    t_row                  w_new_row;

    function automatic logic [COUNT_BITS-1:0] f_sat(input logic [COUNT_BITS-1:0] v);
        return (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic logic [SET_W-1:0] f_set(input logic [ADDR_BITS-1:0] a,
                                               input logic [OFF_CFG_W-1:0] off,
                                               input logic [SET_W-1:0] mask);
        logic [ADDR_BITS-1:0] s;
        s = a >> off;
        return s[SET_W-1:0] & mask;
    endfunction

    function automatic logic [ADDR_BITS-1:0] f_tag(input logic [ADDR_BITS-1:0] a,
                                                   input logic [OFF_CFG_W-1:0] off,
                                                   input logic [4:0] sb);
        return a >> ({1'b0, off} + {1'b0, sb});
    endfunction

    always_comb begin
        w_off = (r_cfg_off > OFF_MAX) ? OFF_MAX : r_cfg_off;
        w_sb  = ({1'b0, r_cfg_sets} > 5'(MSB)) ? 5'(MSB) : {1'b0, r_cfg_sets};
        if (r_cfg_ways == '0) begin
            w_ways = WCNT_W'(1);
        end else if (32'(r_cfg_ways) > MAX_WAYS) begin
            w_ways = WCNT_W'(MAX_WAYS);
        end else begin
            w_ways = WCNT_W'(r_cfg_ways);
        end
        w_smask = ~({SET_W{1'b1}} << w_sb);
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_off  <= OFF_CFG_W'(4);
            r_cfg_sets <= '0;
            r_cfg_ways <= WAY_CFG_W'(1);
            r_cfg_pf   <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_OFFSET_BITS:     r_cfg_off  <= i_cfg.data;
                CFG_SET_BITS:        r_cfg_sets <= i_cfg.data[SET_CFG_W-1:0];
                CFG_WAYS_IN_USE:     r_cfg_ways <= i_cfg.data[WAY_CFG_W-1:0];
                CFG_PREFETCH_ENABLE: r_cfg_pf   <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_lk_tag = (r_state == S_LOOK_PREFETCH) ? r_ptag : r_tag;
        w_found  = 1'b0;
        w_lk_hit = 1'b0;
        w_slot   = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (!w_found && w < int'(w_ways)) begin
                if (!r_rd_row[w][ENT_W-1]) begin
                    w_found = 1'b1;
                    w_slot  = WAY_W'(w);
                end else if (r_rd_row[w][ADDR_BITS-1:0] == w_lk_tag) begin
                    w_found  = 1'b1;
                    w_lk_hit = 1'b1;
                    w_slot   = WAY_W'(w);
                end
            end
        end
        w_victim = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (w < int'(w_ways) && r_rd_row[w][ADDR_BITS +: STAMP_W]
                    <= r_rd_row[w_victim][ADDR_BITS +: STAMP_W]) begin
                w_victim = WAY_W'(w);
            end
        end
        if (!w_found) begin
            w_slot = w_victim;
        end
        w_new_row         = r_rd_row;
        w_new_row[w_slot] = {1'b1, r_clock + 1'b1, w_lk_tag};
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_row;
        end
        if (w_rd_en) begin
            r_rd_row <= mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
        end else begin
            r_state   <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
            r_clock   <= '0;
            r_hc      <= '0;
            r_mc      <= '0;
            r_rc      <= '0;
            r_wc      <= '0;
            r_oval    <= 1'b0;
        end else begin
            r_clr_idx <= n_clr_idx;
            r_clock   <= n_clock;
            r_hc      <= n_hc;
            r_mc      <= n_mc;
            r_rc      <= n_rc;
            r_wc      <= n_wc;
            r_oval    <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_mode  <= n_mode;
        r_set   <= n_set;
        r_tag   <= n_tag;
        r_pset  <= n_pset;
        r_ptag  <= n_ptag;
        r_paddr <= n_paddr;
        r_hit   <= n_hit;
        r_pf    <= n_pf;
    end

    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        n_addr    = r_addr;
        n_mode    = r_mode;
        n_set     = r_set;
        n_tag     = r_tag;
        n_pset    = r_pset;
        n_ptag    = r_ptag;
        n_paddr   = r_paddr;
        n_clock   = r_clock;
        n_hc      = r_hc;
        n_mc      = r_mc;
        n_rc      = r_rc;
        n_wc      = r_wc;
        n_hit     = r_hit;
        n_pf      = r_pf;
        n_oval    = r_oval && !o_out.ready;
        w_rd_en   = 1'b0;
        w_rd_addr = f_set(i_in.address, w_off, w_smask);
        w_wr_en   = 1'b0;
        w_wr_addr = r_set;
        w_wr_row  = w_new_row;
        i_in.ready = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_clr_idx;
                w_wr_row  = '0;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == LAST_SET) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    w_rd_en = 1'b1;
                    n_addr  = i_in.address;
                    n_mode  = i_in.mode;
                    n_set   = w_rd_addr;
                    n_tag   = f_tag(i_in.address, w_off, w_sb);
                    n_state = S_LOOK_DEMAND;
                end
            end
            S_LOOK_DEMAND: begin
                w_wr_en = 1'b1;
                n_clock = r_clock + 1'b1;
                n_hit   = w_lk_hit;
                n_pf    = 1'b0;
                n_paddr = r_addr + (ADDR_BITS'(1) << w_off);
                if (r_mode) begin
                    n_wc = f_sat(r_wc);
                end
                if (w_lk_hit) begin
                    n_hc    = f_sat(r_hc);
                    n_state = S_FINISH;
                end else begin
                    n_mc    = f_sat(r_mc);
                    n_rc    = f_sat(r_rc);
                    n_state = r_cfg_pf ? S_READ_PREFETCH : S_FINISH;
                end
            end
            S_READ_PREFETCH: begin
                w_rd_en   = 1'b1;
                w_rd_addr = f_set(r_paddr, w_off, w_smask);
                n_pset    = w_rd_addr;
                n_ptag    = f_tag(r_paddr, w_off, w_sb);
                n_state   = S_LOOK_PREFETCH;
            end
            S_LOOK_PREFETCH: begin
                w_wr_addr = r_pset;
                if (!w_lk_hit) begin
                    w_wr_en = 1'b1;
                    n_clock = r_clock + 1'b1;
                    n_rc    = f_sat(r_rc);
                    n_pf    = 1'b1;
                end
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_oval || o_out.ready) begin
                    n_oval  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FINISH && (!r_oval || o_out.ready)) begin
            o_out.was_hit         <= r_hit;
            o_out.prefetch_filled <= r_pf;
            o_out.hit_total       <= TOTAL_W'(r_hc);
            o_out.miss_total      <= TOTAL_W'(r_mc);
            o_out.mem_read_total  <= TOTAL_W'(r_rc);
            o_out.mem_write_total <= TOTAL_W'(r_wc);
        end
    end

    assign o_out.valid = r_oval;

endmodule
